FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define SQE_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("sqerr check failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define SQE_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("sqerr check failed");

`endif

FILE: rtl/sqerr_pkg.sv
// ----------------------------------------------------------------------------
// sqerr_pkg
// Codes, command and status types, and a saturation helper of the loss block.
// ----------------------------------------------------------------------------
`default_nettype none

package sqerr_pkg;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_GRAD = 2'd1;
  localparam logic [1:0] MODE_HESS = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_SQ   = 2'd1;
  localparam logic [1:0] MUL_GRAD = 2'd2;
  localparam logic [1:0] MUL_HESS = 2'd3;

  localparam int SumW = 48;
  localparam logic signed [15:0] OneQ12 = 16'sd4096;
  localparam logic signed [15:0] TwoQ12 = 16'sd8192;

  typedef struct packed {
    logic       load;
    logic [1:0] mul_op;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       has_h;
    logic       out_free;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sqerr_ctrl.sv
// ----------------------------------------------------------------------------
// sqerr_ctrl
// Sequencer that steps one element through the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sqerr_ctrl
  import sqerr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] mode_i,
  input  wire logic       has_up_hess_i,
  output logic            in_stall_o,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_HESS = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.mul_op  = MUL_NONE;
    cmd_o.finish  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (mode_i)
            MODE_FWD:  state_d = S_SQ;
            MODE_GRAD: state_d = S_GRAD;
            MODE_HESS: state_d = has_up_hess_i ? S_SQ : S_GRAD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SQ: begin
        cmd_o.mul_op = MUL_SQ;
        state_d = (status_i.mode == MODE_FWD) ? S_DONE : S_GRAD;
      end
      S_GRAD: begin
        cmd_o.mul_op = MUL_GRAD;
        state_d = (status_i.mode == MODE_HESS && status_i.has_h) ? S_HESS : S_DONE;
      end
      S_HESS: begin
        cmd_o.mul_op = MUL_HESS;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sqerr_dp.sv
// ----------------------------------------------------------------------------
// sqerr_dp
// Operand registers, shared multiplier, accumulator, rounding and output.
// ----------------------------------------------------------------------------
`default_nettype none

module sqerr_dp
  import sqerr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic                simple_hessian_i,
  input  wire logic [1:0]          mode_i,
  input  wire logic signed [15:0]  prediction_i,
  input  wire logic signed [15:0]  target_i,
  input  wire logic signed [15:0]  up_grad_i,
  input  wire logic                has_up_grad_i,
  input  wire logic signed [15:0]  up_hess_i,
  input  wire logic                has_up_hess_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SumW-1:0]          error_sum_o,
  output logic signed [15:0]       in_grad_o,
  output logic signed [15:0]       in_hess_o,
  output logic                     last_out_o
);

  logic [1:0]         mode_q;
  logic               has_h_q;
  logic               last_q;
  logic signed [17:0] fp_q;
  logic signed [15:0] g_q;
  logic signed [15:0] h_q;

  logic [33:0]        sq_q;
  logic signed [33:0] grad_q;
  logic signed [49:0] hess_q;

  logic [SumW-1:0]    sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [SumW-1:0]    error_sum_q;
  logic signed [15:0] in_grad_q, in_hess_q;
  logic               last_out_q;

  logic signed [16:0] diff;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;

  logic [SumW:0]      sum_add;
  logic [SumW-1:0]    sum_sat;
  logic signed [35:0] grad_rnd;
  logic signed [40:0] hess_term;
  logic signed [51:0] hess_rnd;
  logic signed [15:0] grad_res;
  logic signed [15:0] hess_res;

  assign diff = {prediction_i[15], prediction_i} - {target_i[15], target_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      has_h_q <= has_up_hess_i;
      last_q  <= last_i;
      fp_q    <= {diff, 1'b0};
      g_q     <= has_up_grad_i ? up_grad_i : OneQ12;
      h_q     <= up_hess_i;
    end
  end

  always_comb begin
    mul_a = {{18{fp_q[17]}}, fp_q};
    mul_b = fp_q;
    case (cmd_i.mul_op)
      MUL_GRAD: mul_b = {{2{g_q[15]}}, g_q};
      MUL_HESS: begin
        mul_a = {2'b00, sq_q};
        mul_b = {{2{h_q[15]}}, h_q};
      end
      default: mul_b = fp_q;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op == MUL_SQ) begin
      sq_q <= mul_p[33:0];
    end
    if (cmd_i.mul_op == MUL_GRAD) begin
      grad_q <= mul_p[33:0];
    end
    if (cmd_i.mul_op == MUL_HESS) begin
      hess_q <= mul_p[49:0];
    end
  end

  // The squared product holds (2d)^2, so the element square is that over four.
  assign sum_add = {1'b0, sum_q} + {{(SumW - 31){1'b0}}, sq_q[33:2]};
  assign sum_sat = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];

  assign grad_rnd  = {{2{grad_q[33]}}, grad_q} + 36'sd2048;
  assign grad_res  = sat16({{16{grad_rnd[35]}}, grad_rnd[35:12]});
  assign hess_term = simple_hessian_i ? 41'sd0 : {{25{g_q[15]}}, g_q} <<< 25;
  assign hess_rnd  = {{2{hess_q[49]}}, hess_q} + {{11{hess_term[40]}}, hess_term}
                   + (52'sd1 <<< 35);
  assign hess_res  = sat16({{24{hess_rnd[51]}}, hess_rnd[51:36]});

  assign status_o.mode     = mode_q;
  assign status_o.has_h    = has_h_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (mode_q == MODE_FWD) begin
        sum_d = last_q ? '0 : sum_sat;
        out_valid_d = last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      last_out_q <= last_q;
      if (mode_q == MODE_FWD) begin
        error_sum_q <= sum_sat;
        in_grad_q   <= '0;
        in_hess_q   <= '0;
      end else begin
        error_sum_q <= '0;
        in_grad_q   <= grad_res;
        if (mode_q == MODE_HESS) begin
          in_hess_q <= has_h_q ? hess_res : TwoQ12;
        end else begin
          in_hess_q <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign error_sum_o = error_sum_q;
  assign in_grad_o   = in_grad_q;
  assign in_hess_o   = in_hess_q;
  assign last_out_o  = last_out_q;

endmodule

`default_nettype wire

FILE: rtl/squared_error_loss_grad.sv
// ----------------------------------------------------------------------------
// squared_error_loss_grad
// Squared-error loss with gradient and diagonal hessian, one element a word.
// ----------------------------------------------------------------------------
// Each input word carries one prediction and target pair in signed Q4.12 and
// one of three modes. Forward mode adds the squared error to a saturating
// Q24.24 sum and delivers that sum on the word marked last, then clears it.
// Gradient mode delivers 2(x-t)g, and hessian mode adds the diagonal hessian
// element. All products run through one shared 36x18 multiplier: forward mode
// takes the square, gradient mode and hessian mode without an upstream
// hessian the gradient, and hessian mode with one the square, gradient and
// hessian in turn, with the input stalled until the result register is
// loaded; a word with mode 3 is taken and dropped without a stall.
// The result register lets the next word enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module squared_error_loss_grad
  import sqerr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic signed [15:0]  prediction_i,
  input  wire logic signed [15:0]  target_i,
  input  wire logic signed [15:0]  up_grad_i,
  input  wire logic                has_up_grad_i,
  input  wire logic signed [15:0]  up_hess_i,
  input  wire logic                has_up_hess_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SumW-1:0]          error_sum_o,
  output logic signed [15:0]       in_grad_o,
  output logic signed [15:0]       in_hess_o,
  output logic                     last_out_o
);

  logic    simple_q, simple_d;
  cmd_t    cmd;
  status_t status;

  assign pready   = 1'b1;
  assign simple_d = (psel && penable && pwrite && (paddr[2] == 1'b0)) ? pwdata[0]
                  : simple_q;
  assign prdata   = (paddr[2] == 1'b0) ? {31'd0, simple_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      simple_q <= 1'b0;
    end else begin
      simple_q <= simple_d;
    end
  end

  sqerr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .mode_i        (mode_i),
    .has_up_hess_i (has_up_hess_i),
    .in_stall_o    (in_stall_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  sqerr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .simple_hessian_i (simple_q),
    .mode_i           (mode_i),
    .prediction_i     (prediction_i),
    .target_i         (target_i),
    .up_grad_i        (up_grad_i),
    .has_up_grad_i    (has_up_grad_i),
    .up_hess_i        (up_hess_i),
    .has_up_hess_i    (has_up_hess_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .error_sum_o      (error_sum_o),
    .in_grad_o        (in_grad_o),
    .in_hess_o        (in_hess_o),
    .last_out_o       (last_out_o)
  );

  `SQE_ASSERT_NXT(a_drop_unused, clk_i, rst_ni,
    in_valid_i && !in_stall_o && mode_i == MODE_NONE, !in_stall_o)
  `SQE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && !in_stall_o && mode_i != MODE_NONE, in_stall_o)
  `SQE_ASSERT_IMP(a_sum_only_on_last, clk_i, rst_ni,
    out_valid_o && !last_out_o, error_sum_o == '0)
  `SQE_ASSERT_IMP(a_sum_excludes_grad, clk_i, rst_ni,
    out_valid_o && error_sum_o != '0, in_grad_o == '0 && in_hess_o == '0)

endmodule

`default_nettype wire
